// ===== design/sts_pkg.sv =====
// Shared types and constants for the trimmed order-statistic selector.
`default_nettype none
package sts_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned KEEP_W = 6;

  // Q16.16 value -32766.0; samples below it are invalid
  localparam logic signed [DATA_W-1:0] INVALID_LIMIT = 32'sh8002_0000;

  // Register indexes
  localparam logic REG_KEEP_COUNT = 1'b0;
  localparam logic REG_FILL_VALUE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP,
    OP_ROTATE,
    OP_CLEAR
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    data_t    x;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_DECIDE,
    ST_FILL,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    MD_PASS,
    MD_CONST,
    MD_SORT
  } mode_t;

endpackage
`default_nettype wire

// ===== design/sts_if.sv =====
// Valid/ready channel interfaces for samples and selected results.
`default_nettype none
interface sts_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample;
  logic               last_sample;
  modport source (output valid, output sample, output last_sample, input ready);
  modport sink (input valid, input sample, input last_sample, output ready);
endinterface

interface sts_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] selected;
  logic               last_selected;
  modport source (output valid, output selected, output last_selected, input ready);
  modport sink (input valid, input selected, input last_selected, output ready);
endinterface
`default_nettype wire

// ===== design/stack_trimmed_select.sv =====
// Top level: trimmed order-statistic selection over a stack of samples.
//
//  channel  | dir | handshake         | payload
//  in_ch    | in  | valid/ready       | sample, last_sample
//  out_ch   | out | valid/ready       | selected, last_selected
//  cfg_*    | in  | APB, pready = 1   | keep_count (0x0), fill_value (0x4)
//
// Samples are taken one per cycle while a pixel is collected; each stored
// one enters the arrival-order chain and, if valid, the sorted valid chain
// and the sorted working chain. After the last sample comes a decide state;
// when trimming sorted values, a fill state feeds the rotating valid chain
// into the working chain, (count - valid) values, and a skip state pops the
// lowest (count-keep)/2; then one result per cycle while the receiver is ready.
// Input is held off from the last sample until its pixel is emitted or dropped.
// Reset is synchronous; chains come up empty and need no clearing pass.
`default_nettype none
module stack_trimmed_select
  import sts_pkg::*;
#(
  parameter int unsigned MAX_OBS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sts_in_if.sink           in_ch,
  sts_out_if.source        out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int unsigned CW = $clog2(MAX_OBS + 1);
  localparam int unsigned WW = (CW > KEEP_W) ? CW : KEEP_W;

  // Configuration registers
  logic [KEEP_W-1:0] keep_r;
  data_t             fill_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r <= KEEP_W'(10);
      fill_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (cfg_paddr[2])
        REG_KEEP_COUNT: keep_r <= cfg_pwdata[KEEP_W-1:0];
        REG_FILL_VALUE: fill_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      REG_KEEP_COUNT: cfg_prdata = {{(32-KEEP_W){1'b0}}, keep_r};
      REG_FILL_VALUE: cfg_prdata = fill_r;
      default:        cfg_prdata = '0;
    endcase
  end

  // Control state
  state_t        state_r, state_nxt;
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] nv_r, nv_nxt;
  logic [CW-1:0] fcnt_r, fcnt_nxt;
  logic [CW-1:0] skip_r, skip_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic          out_valid_r, out_valid_nxt;
  data_t         out_data_r, out_data_nxt;
  logic          out_last_r, out_last_nxt;

  cell_cmd_t cmd_arr, cmd_val, cmd_work;
  data_t     head_arr, head_val, head_work;

  logic          in_acc, room, s_ok, load;
  logic [WW-1:0] n_ext, k_ext, diff;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign room   = (cnt_r < CW'(MAX_OBS));
  assign s_ok   = (in_ch.sample >= INVALID_LIMIT);
  assign n_ext  = WW'(cnt_r);
  assign k_ext  = WW'(keep_r);
  assign diff   = n_ext - k_ext;
  assign load   = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready          = (state_r == ST_COLLECT);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.selected      = out_data_r;
  assign out_ch.last_selected = out_last_r;

  sts_chain #(.DEPTH(MAX_OBS), .SORTED(1'b0)) u_arr (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_arr), .head(head_arr));
  sts_chain #(.DEPTH(MAX_OBS), .SORTED(1'b1)) u_val (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_val), .head(head_val));
  sts_chain #(.DEPTH(MAX_OBS), .SORTED(1'b1)) u_work (
    .clk(clk), .rst_n(rst_n), .cmd(cmd_work), .head(head_work));

  // Next state, chain commands and output register loading
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    cnt_nxt       = cnt_r;
    nv_nxt        = nv_r;
    fcnt_nxt      = fcnt_r;
    skip_nxt      = skip_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    cmd_arr       = '{op: OP_HOLD, x: in_ch.sample};
    cmd_val       = '{op: OP_HOLD, x: in_ch.sample};
    cmd_work      = '{op: OP_HOLD, x: in_ch.sample};

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (room) begin
            cnt_nxt    = cnt_r + 1'b1;
            cmd_arr.op = OP_INSERT;
            if (s_ok) begin
              nv_nxt      = nv_r + 1'b1;
              cmd_val.op  = OP_INSERT;
              cmd_work.op = OP_INSERT;
            end
          end
          if (in_ch.last_sample) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        cnt_nxt  = '0;
        nv_nxt   = '0;
        fcnt_nxt = cnt_r - nv_r;
        skip_nxt = CW'(diff >> 1);
        if (n_ext <= k_ext) begin
          mode_nxt  = MD_PASS;
          rem_nxt   = cnt_r;
          state_nxt = ST_EMIT;
        end else if (keep_r == '0) begin
          // nothing to emit: drop the pixel
          cmd_arr.op  = OP_CLEAR;
          cmd_val.op  = OP_CLEAR;
          cmd_work.op = OP_CLEAR;
          state_nxt   = ST_COLLECT;
        end else if (nv_r == '0) begin
          mode_nxt  = MD_CONST;
          rem_nxt   = CW'(keep_r);
          state_nxt = ST_EMIT;
        end else begin
          mode_nxt  = MD_SORT;
          rem_nxt   = CW'(keep_r);
          state_nxt = (cnt_r == nv_r) ? ST_SKIP : ST_FILL;
        end
      end
      ST_FILL: begin
        // feed valid values cyclically into the working set
        cmd_val.op  = OP_ROTATE;
        cmd_work.op = OP_INSERT;
        cmd_work.x  = head_val;
        fcnt_nxt    = fcnt_r - 1'b1;
        if (fcnt_r == CW'(1)) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (skip_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd_work.op = OP_POP;
          skip_nxt    = skip_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rem_r == CW'(1));
          rem_nxt       = rem_r - 1'b1;
          case (mode_r)
            MD_PASS: begin
              out_data_nxt = head_arr;
              cmd_arr.op   = OP_POP;
            end
            MD_CONST: out_data_nxt = fill_r;
            MD_SORT: begin
              out_data_nxt = head_work;
              cmd_work.op  = OP_POP;
            end
            default: out_data_nxt = fill_r;
          endcase
          if (rem_r == CW'(1)) begin
            cmd_arr.op  = OP_CLEAR;
            cmd_val.op  = OP_CLEAR;
            cmd_work.op = OP_CLEAR;
            state_nxt   = ST_COLLECT;
          end
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_COLLECT;
      mode_r      <= MD_PASS;
      cnt_r       <= '0;
      nv_r        <= '0;
      fcnt_r      <= '0;
      skip_r      <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      nv_r        <= nv_nxt;
      fcnt_r      <= fcnt_nxt;
      skip_r      <= skip_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  // Checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_OBS))
    else $error("sample count beyond buffer depth");

  a_nv_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nv_r <= cnt_r)
    else $error("valid count exceeds sample count");

  a_last_stops_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.last_sample) |=> !in_ch.ready)
    else $error("input taken right after pixel end");

  a_emit_quiet_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !in_ch.ready)
    else $error("input open during result burst");

endmodule
`default_nettype wire

// ===== design/sts_cell.sv =====
// One cell of a value chain: holds one entry and trades with its neighbors.
`default_nettype none
module sts_cell
  import sts_pkg::*;
#(
  parameter bit SORTED = 1'b1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  input  wire data_t     head,
  input  wire logic      prev_ins,
  input  wire data_t     prev_val,
  input  wire logic      prev_occ,
  input  wire data_t     next_val,
  input  wire logic      next_occ,
  output data_t          val,
  output logic           occ,
  output logic           ins
);

  data_t val_r;
  logic  occ_r;

  // Insertion point: first empty cell, or first one holding a larger value
  assign ins = !occ_r || (SORTED && (val_r > cmd.x));
  assign val = val_r;
  assign occ = occ_r;

  // Occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_INSERT: begin
          if (ins) begin
            occ_r <= prev_ins ? prev_occ : 1'b1;
          end
        end
        OP_POP:   occ_r <= next_occ;
        OP_CLEAR: occ_r <= 1'b0;
        default:  occ_r <= occ_r;
      endcase
    end
  end

  // Value
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_INSERT: begin
        if (ins) begin
          val_r <= prev_ins ? prev_val : cmd.x;
        end
      end
      OP_POP: val_r <= next_val;
      OP_ROTATE: begin
        if (next_occ) begin
          val_r <= next_val;
        end else if (occ_r) begin
          val_r <= head;
        end
      end
      default: val_r <= val_r;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/sts_chain.sv =====
// Row of cells forming an ordered or arrival-order value chain.
`default_nettype none
module sts_chain
  import sts_pkg::*;
#(
  parameter int unsigned DEPTH  = 32,
  parameter bit          SORTED = 1'b1
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire cell_cmd_t cmd,
  output data_t          head
);

  data_t val [DEPTH];
  logic  occ [DEPTH];
  logic  ins [DEPTH];

  assign head = val[0];

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    data_t p_val;
    logic  p_occ;
    logic  p_ins;
    data_t n_val;
    logic  n_occ;

    if (k == 0) begin : g_first
      assign p_val = cmd.x;
      assign p_occ = 1'b1;
      assign p_ins = 1'b0;
    end else begin : g_mid
      assign p_val = val[k-1];
      assign p_occ = occ[k-1];
      assign p_ins = ins[k-1];
    end

    if (k == DEPTH - 1) begin : g_tail
      assign n_val = '0;
      assign n_occ = 1'b0;
    end else begin : g_body
      assign n_val = val[k+1];
      assign n_occ = occ[k+1];
    end

    sts_cell #(.SORTED(SORTED)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .head     (val[0]),
      .prev_ins (p_ins),
      .prev_val (p_val),
      .prev_occ (p_occ),
      .next_val (n_val),
      .next_occ (n_occ),
      .val      (val[k]),
      .occ      (occ[k]),
      .ins      (ins[k])
    );
  end

endmodule
`default_nettype wire

// ===== test/stack_trimmed_select_tb.sv =====
// Testbench for the trimmed order-statistic selector: directed table, then random pixels.
`timescale 1ns / 1ps
module stack_trimmed_select_tb;
  import sts_pkg::*;

  localparam int unsigned NOBS = 32;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam logic [2:0] ADDR_KEEP = 3'(4 * REG_KEEP_COUNT);
  localparam logic [2:0] ADDR_FILL = 3'(4 * REG_FILL_VALUE);
  localparam logic [31:0] NEG_FULL = 32'h8000_0000;
  localparam logic [31:0] POS_FULL = 32'h7fff_ffff;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  sts_in_if  in_ch ();
  sts_out_if out_ch ();

  stack_trimmed_select #(.MAX_OBS(NOBS)) dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #5 clk = ~clk;

  // Predictor state
  logic [5:0]  keep_cnt;
  logic [31:0] fill_val;
  logic [31:0] pixel_buf[NOBS];
  int unsigned pixel_cnt;
  pick_t       picks_due[$];

  int unsigned errors = 0;
  int unsigned samples_sent = 0;
  int unsigned picks_seen = 0;
  int unsigned pixels_sent = 0;
  int unsigned idle_cycles = 0;
  bit          stall_long = 1'b0;
  bit          sender_busy = 1'b0;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, picks_seen);
  endtask

  function automatic bit lower(input logic [31:0] a, input logic [31:0] b);
    return $signed(a) < $signed(b);
  endfunction

  // Append one expected pick at the tail of the queue
  task automatic queue_pick(input logic [31:0] v, input logic l);
    pick_t p;
    p.value = v;
    p.last = l;
    picks_due.insert(picks_due.size(), p);
  endtask

  // Sort in place, ascending signed order
  task automatic sort_vals(ref logic [31:0] a[NOBS], input int unsigned n);
    int unsigned i, j;
    logic [31:0] v;
    for (i = 1; i < n; i++) begin
      v = a[i];
      j = i;
      while (j > 0 && lower(v, a[j-1])) begin
        a[j] = a[j-1];
        j--;
      end
      a[j] = v;
    end
  endtask

  // Advance the predictor by one accepted sample and queue the picks it causes
  task automatic predict_sample(input logic [31:0] s, input logic last);
    logic [31:0] good[NOBS];
    logic [31:0] pool[NOBS];
    int unsigned n, ngood, i, left;
    if (pixel_cnt < NOBS) begin
      pixel_buf[pixel_cnt] = s;
      pixel_cnt++;
    end
    if (!last) return;
    n = pixel_cnt;
    pixel_cnt = 0;
    if (n <= keep_cnt) begin
      for (i = 0; i < n; i++) queue_pick(pixel_buf[i], i + 1 == n);
      return;
    end
    ngood = 0;
    for (i = 0; i < n; i++)
      if (!lower(pixel_buf[i], INVALID_LIMIT)) begin
        good[ngood] = pixel_buf[i];
        ngood++;
      end
    if (ngood == 0) begin
      for (i = 0; i < keep_cnt; i++) queue_pick(fill_val, i + 1 == keep_cnt);
      return;
    end
    sort_vals(good, ngood);
    for (i = 0; i < n; i++) pool[i] = (i < ngood) ? good[i] : good[(i - ngood) % ngood];
    sort_vals(pool, n);
    left = (n - keep_cnt) / 2;
    for (i = 0; i < keep_cnt; i++) queue_pick(pool[left + i], i + 1 == keep_cnt);
  endtask

  // Write one register through the APB port
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_KEEP) keep_cnt = data[5:0];
    else if (addr == ADDR_FILL) fill_val = data;
  endtask

  task automatic set_config(input logic [5:0] keep, input logic [31:0] fill);
    write_reg(ADDR_KEEP, 32'(keep));
    write_reg(ADDR_FILL, fill);
  endtask

  // Offer one sample; hold it until accepted, with random gaps between bursts
  task automatic send_sample(input logic [31:0] s, input logic last);
    if (!sender_busy && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    sender_busy = ($urandom_range(0, 7) != 0);
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.last_sample <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_sample(s, last);
    samples_sent++;
    if (last) pixels_sent++;
  endtask

  // Wait until every expected pick is out, plus the tail latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (picks_due.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return NEG_FULL + 32'($urandom_range(0, 32'h3ffff));
      1: return POS_FULL - 32'($urandom_range(0, 15));
      2: return INVALID_LIMIT + 32'($urandom_range(0, 2)) - 32'd1;
      3, 4: return 32'($urandom_range(0, 15)) << 16;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_pixel(input int unsigned n, input int unsigned bad_pct);
    int unsigned i;
    logic [31:0] s;
    for (i = 0; i < n; i++) begin
      s = rand_sample();
      if ($urandom_range(0, 99) < bad_pct) s = NEG_FULL + 32'($urandom_range(0, 32'h1ffff));
      send_sample(s, i + 1 == n);
    end
  endtask

  // Receiver: stall on its own pattern, with one long hold-off
  initial begin
    int unsigned k;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_long) begin
        out_ch.ready <= 1'b0;
        for (k = 0; k < 300; k++) @(posedge clk);
        stall_long = 1'b0;
      end
      case ($urandom_range(0, 15))
        0, 1, 2: out_ch.ready <= 1'b0;
        default: out_ch.ready <= 1'b1;
      endcase
    end
  end

  // Check each accepted pick against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      picks_seen++;
      if (picks_due.size() == 0) begin
        report("unexpected result", out_ch.selected, 32'h0);
      end else begin
        if (out_ch.selected !== picks_due[0].value)
          report("selected", out_ch.selected, picks_due[0].value);
        if (out_ch.last_selected !== picks_due[0].last)
          report("last_selected", 32'(out_ch.last_selected), 32'(picks_due[0].last));
        void'(picks_due.pop_front());
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Watchdog expired, %0d results outstanding", picks_due.size());
      $display("Some tests failed");
      $finish;
    end
  end

  typedef struct {
    logic [31:0] s;
    logic        last;
    bit          typed;
    logic [31:0] want;
  } row_t;

  // Directed rows: keep_count reset value 10; short pixels pass through
  row_t rows[] = '{
    '{NEG_FULL, 1'b1, 1'b1, NEG_FULL},
    '{POS_FULL, 1'b1, 1'b1, POS_FULL},
    '{32'h0001_0000, 1'b0, 1'b1, 32'h0001_0000},
    '{INVALID_LIMIT - 32'd1, 1'b1, 1'b1, INVALID_LIMIT - 32'd1},
    '{INVALID_LIMIT, 1'b0, 1'b0, '0},
    '{INVALID_LIMIT - 32'd1, 1'b0, 1'b0, '0},
    '{32'hffff_0000, 1'b0, 1'b0, '0},
    '{32'h0003_8000, 1'b1, 1'b0, '0}
  };

  initial begin
    int unsigned r, i, n;
    logic [5:0] keeps[6];
    keeps = '{6'd1, 6'd2, 6'd0, 6'd5, 6'd32, 6'd63};
    in_ch.valid <= 1'b0;
    in_ch.sample <= '0;
    in_ch.last_sample <= 1'b0;
    keep_cnt = 6'd10;
    fill_val = '0;
    pixel_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table under reset config; typed rows that close a pixel are checked
    for (r = 0; r < rows.size(); r++) begin
      send_sample(rows[r].s, rows[r].last);
      if (rows[r].typed && rows[r].last && picks_due.size() != 0 &&
          picks_due[$].value !== rows[r].want)
        report("table row", picks_due[$].value, rows[r].want);
    end
    drain();

    // Trimming with keep 2: mixed valid/invalid, all invalid, buffer overflow
    set_config(6'd2, 32'h1234_5678);
    send_pixel(5, 40);
    send_pixel(4, 100);
    for (i = 0; i < 35; i++) send_sample(rand_sample(), i == 34);
    drain();
    // keep zero, then extreme fill values
    set_config(6'd0, NEG_FULL);
    send_pixel(3, 0);
    drain();
    set_config(6'd1, POS_FULL);
    send_pixel(3, 100);
    drain();
    set_config(6'd1, NEG_FULL);
    send_pixel(2, 100);
    drain();

    // Long receiver hold-off while input keeps coming
    set_config(6'd10, 32'h0000_8000);
    stall_long = 1'b1;
    send_pixel(20, 20);
    send_pixel(16, 10);
    drain();

    // Random phases over several settings
    for (r = 0; r < 6; r++) begin
      set_config(keeps[r], $urandom);
      while (samples_sent < 60 + 60 * (r + 1)) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 36) : $urandom_range(1, 14);
        send_pixel(n, $urandom_range(0, 3) == 0 ? 100 : $urandom_range(0, 50));
      end
      drain();
    end

    $display("Covered %0d samples in %0d pixels, %0d results checked", samples_sent,
             pixels_sent, picks_seen);
    $display("keep counts 0..63, pass-through, trimming, all-invalid and overflow pixels");
    if (errors == 0 && picks_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
